// ----- rtl/bch_63_51_codec_unit_defines.svh -----
// ---------------------------------------------------------------------------
// bch_63_51_codec_unit_defines
// Assertion macros shared by the codec RTL.
// ---------------------------------------------------------------------------
`ifndef BCH_63_51_CODEC_UNIT_DEFINES_SVH
`define BCH_63_51_CODEC_UNIT_DEFINES_SVH

// same-cycle implication
`define BCH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication on the next edge
`define BCH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bch_pkg.sv -----
// ---------------------------------------------------------------------------
// bch_pkg
// GF(64) helpers, code constants and shared stage types.
// ---------------------------------------------------------------------------
package bch_pkg;

  localparam int CodeN   = 63;
  localparam int MsgK    = 51;
  localparam int ParBits = 12;
  localparam logic [12:0] CODE_GEN = 13'h1927;
  localparam logic [5:0]  PRIM_LOW = 6'h1B;   // x^6 folded back

  typedef enum logic {FN_ENC = 1'b0, FN_DEC = 1'b1} func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ONE  = 2'd1,
    ST_TWO  = 2'd2,
    ST_FAIL = 2'd3
  } status_t;

  typedef struct packed {
    logic        valid;
    logic [62:0] word;
    logic [5:0]  s1;
    logic [5:0]  s3;
  } syn_t;

  typedef struct packed {
    logic        valid;
    logic [62:0] word;
    logic [5:0]  s1;
    logic [5:0]  sigma2;
    status_t     kind;
    logic [62:0] one_mask;
  } key_t;

  function automatic logic [5:0] gf_alpha(input logic [5:0] v);
    return {v[4:0], 1'b0} ^ (v[5] ? PRIM_LOW : 6'd0);
  endfunction

  function automatic logic [5:0] gf_mul(input logic [5:0] a, input logic [5:0] b);
    logic [5:0] acc;
    logic [5:0] t;
    acc = '0;
    t = a;
    for (int i = 0; i < 6; i++) begin
      if (b[i]) acc = acc ^ t;
      t = gf_alpha(t);
    end
    return acc;
  endfunction

  // alpha^e, constant arguments only
  function automatic logic [5:0] alpha_pow(input int e);
    logic [5:0] v;
    v = 6'd1;
    for (int k = 0; k < CodeN; k++) begin
      if (k < e) v = gf_alpha(v);
    end
    return v;
  endfunction

  // parallel compare against all nonzero candidates; zero maps to zero
  function automatic logic [5:0] gf_inv(input logic [5:0] a);
    logic [5:0] r;
    r = '0;
    for (int k = 1; k < 64; k++) begin
      if (gf_mul(a, 6'(k)) == 6'd1) r = 6'(k);
    end
    return r;
  endfunction

  // parity contribution of message bit j: x^(j+12) mod g(x)
  function automatic logic [11:0] par_col(input int j);
    logic [62:0] rem;
    rem = 63'd1 << (j + ParBits);
    for (int b = CodeN - 1; b >= ParBits; b--) begin
      if (rem[b]) rem = rem ^ (63'(CODE_GEN) << (b - ParBits));
    end
    return rem[11:0];
  endfunction

endpackage

// ----- rtl/bch_syn.sv -----
// ---------------------------------------------------------------------------
// bch_syn
// Stage 1: encoder parity and decoder syndromes S1, S3.
// ---------------------------------------------------------------------------
module bch_syn import bch_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  func_t       in_func,
  input  logic [62:0] in_word,
  output syn_t        syn
);

  logic [11:0] parity;
  logic [5:0]  s1_next;
  logic [5:0]  s3_next;

  always_comb begin
    parity = '0;
    for (int j = 0; j < MsgK; j++) begin
      if (in_word[j]) parity = parity ^ par_col(j);
    end
    s1_next = '0;
    s3_next = '0;
    for (int i = 0; i < CodeN; i++) begin
      if (in_word[i]) begin
        s1_next = s1_next ^ alpha_pow(i);
        s3_next = s3_next ^ alpha_pow((3 * i) % CodeN);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      syn.valid <= 1'b0;
    end else begin
      syn.valid <= in_valid;
    end
    // an encoded word leaves with zero syndromes and passes straight through
    if (in_func == FN_ENC) begin
      syn.word <= {in_word[MsgK-1:0], parity};
      syn.s1   <= '0;
      syn.s3   <= '0;
    end else begin
      syn.word <= in_word;
      syn.s1   <= s1_next;
      syn.s3   <= s3_next;
    end
  end

endmodule

// ----- rtl/bch_key.sv -----
// ---------------------------------------------------------------------------
// bch_key
// Stages 2 and 3: S1^3 and 1/S1, then sigma2 and the error class.
// ---------------------------------------------------------------------------
module bch_key import bch_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  syn_t syn,
  output key_t key
);

  logic        v2;
  logic [62:0] word2;
  logic [5:0]  s1_2, s3_2, cube2, inv2;
  logic [62:0] one_mask;
  status_t     kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= syn.valid;
    end
    word2 <= syn.word;
    s1_2  <= syn.s1;
    s3_2  <= syn.s3;
    cube2 <= gf_mul(gf_mul(syn.s1, syn.s1), syn.s1);
    inv2  <= gf_inv(syn.s1);
  end

  always_comb begin
    one_mask = '0;
    for (int i = 0; i < CodeN; i++) begin
      one_mask[i] = (alpha_pow(i) == s1_2);
    end
    if (s1_2 == 6'd0 && s3_2 == 6'd0) kind = ST_OK;
    else if (s1_2 == 6'd0)            kind = ST_FAIL;
    else if (s3_2 == cube2)           kind = ST_ONE;
    else                              kind = ST_TWO;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key.valid <= 1'b0;
    end else begin
      key.valid <= v2;
    end
    key.word     <= word2;
    key.s1       <= s1_2;
    key.sigma2   <= gf_mul(s3_2 ^ cube2, inv2);
    key.kind     <= kind;
    key.one_mask <= one_mask;
  end

endmodule

// ----- rtl/bch_chien.sv -----
// ---------------------------------------------------------------------------
// bch_chien
// Stages 4 and 5: parallel Chien search over 63 positions, then correction.
// ---------------------------------------------------------------------------
module bch_chien import bch_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  key_t        key,
  output logic        done,
  output logic [62:0] word_out,
  output logic [1:0]  status
);

  `include "bch_63_51_codec_unit_defines.svh"

  logic        v4;
  logic [62:0] word4, mask4, mask_next;
  status_t     kind4;
  logic [5:0]  x;

  always_comb begin
    mask_next = '0;
    for (int i = 0; i < CodeN; i++) begin
      x = alpha_pow(i);
      mask_next[i] = ((gf_mul(x, x) ^ gf_mul(key.s1, x) ^ key.sigma2) == 6'd0);
    end
    if (key.kind == ST_ONE) mask_next = key.one_mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= key.valid;
    end
    word4 <= key.word;
    mask4 <= mask_next;
    kind4 <= key.kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v4;
    end
    case (kind4)
      ST_ONE: begin
        word_out <= word4 ^ mask4;
        status   <= kind4;
      end
      ST_TWO: begin
        if ($countones(mask4) == 2) begin
          word_out <= word4 ^ mask4;
          status   <= kind4;
        end else begin
          word_out <= word4;
          status   <= ST_FAIL;
        end
      end
      default: begin
        word_out <= word4;
        status   <= kind4;
      end
    endcase
  end

  `BCH_ASSERT_NXT(a_corr_weight, v4 && kind4 != ST_FAIL && kind4 != ST_TWO,
    $countones(word_out ^ $past(word4)) == int'(status), "flip count disagrees with status")
  `BCH_ASSERT_NXT(a_fail_pass, v4 && kind4 == ST_FAIL,
    word_out == $past(word4) && status == ST_FAIL, "uncorrectable word altered")
  `BCH_ASSERT_NXT(a_two_flip, v4 && kind4 == ST_TWO,
    status == ST_FAIL || $countones(word_out ^ $past(word4)) == 2, "double fix not two bits")

endmodule

// ----- rtl/bch_63_51_codec_unit.sv -----
// ---------------------------------------------------------------------------
// bch_63_51_codec_unit
// BCH(63,51) double-error-correcting encoder/decoder, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: func, word_in sampled at a rising edge with start high;
//   busy is always low, so a beat may be issued every cycle.
//   func 0 encodes word_in[50:0] into a systematic codeword (message in
//   62..12, parity in 11..0); func 1 decodes a 63-bit received word.
//   Result channel: done is high for one cycle with word_out and status.
//   status: 0 clean/encode, 1 one bit fixed, 2 two fixed, 3 uncorrectable
//   (word returned unchanged).
//   Throughput: one beat per cycle; the stages are the input register,
//   syndrome/parity XOR trees, cube and inverse, sigma2, the 63-lane
//   Chien search and the correction register.
//   Reset clears every valid bit; in-flight beats are dropped.
//   The receiver cannot stall, so nothing backs up into the pipeline.
// ---------------------------------------------------------------------------
module bch_63_51_codec_unit import bch_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [62:0] word_in,
  output logic        done,
  output logic [62:0] word_out,
  output logic [1:0]  status
);

  `include "bch_63_51_codec_unit_defines.svh"

  logic        v0;
  func_t       func0;
  logic [62:0] word0;
  syn_t        syn;
  key_t        key;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    func0 <= func_t'(func);
    word0 <= word_in;
  end

  bch_syn u_syn (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v0),
    .in_func  (func0),
    .in_word  (word0),
    .syn      (syn)
  );

  bch_key u_key (
    .clk (clk),
    .rst (rst),
    .syn (syn),
    .key (key)
  );

  bch_chien u_chien (
    .clk      (clk),
    .rst      (rst),
    .key      (key),
    .done     (done),
    .word_out (word_out),
    .status   (status)
  );

  `BCH_ASSERT_NOW(a_latency, start && !busy, ##6 done, "result missing after fixed latency")
  `BCH_ASSERT_NXT(a_enc_clean, v0 && func0 == FN_ENC, syn.s1 == 6'd0 && syn.s3 == 6'd0,
    "encode beat carries syndromes")

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the BCH(63,51) codec: encode and decode beats with
// random gaps; a local GF(64) predictor queues the expected word and status,
// and a monitor compares every done beat against the oldest expectation.
// ---------------------------------------------------------------------------
module tb_top;
  import bch_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        func;
  logic [62:0] word_in;
  logic        done;
  logic [62:0] word_out;
  logic [1:0]  status;

  logic [62:0] exp_word_q[$];
  logic [1:0]  exp_status_q[$];
  int          err_cnt;

  bch_63_51_codec_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .word_in(word_in), .done(done), .word_out(word_out), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // GF(64), p(x) = x^6 + x^4 + x^3 + x + 1
  function automatic logic [5:0] fld_alpha(input logic [5:0] v);
    return {v[4:0], 1'b0} ^ (v[5] ? 6'h1B : 6'h00);
  endfunction

  function automatic logic [5:0] fld_mul(input logic [5:0] a, input logic [5:0] b);
    logic [5:0] acc;
    acc = '0;
    for (int i = 0; i < 6; i++) begin
      if (b[i]) acc ^= a;
      a = fld_alpha(a);
    end
    return acc;
  endfunction

  function automatic logic [62:0] codeword_of(input logic [62:0] msg);
    logic [62:0] sh;
    logic [62:0] rem;
    sh = {msg[50:0], 12'd0};
    rem = sh;
    for (int b = 62; b >= 12; b--) begin
      if (rem[b]) rem ^= 63'h1927 << (b - 12);
    end
    return sh | {51'd0, rem[11:0]};
  endfunction

  task automatic correct_word(input logic [62:0] r, output logic [62:0] w,
                              output logic [1:0] st);
    logic [5:0] s1, s3, a1, a3, cube, inv, sig2, x;
    logic [62:0] flips;
    int roots;
    s1 = '0; s3 = '0; a1 = 6'd1; a3 = 6'd1; flips = '0; roots = 0;
    for (int i = 0; i < 63; i++) begin
      if (r[i]) begin
        s1 ^= a1;
        s3 ^= a3;
      end
      a1 = fld_alpha(a1);
      a3 = fld_alpha(fld_alpha(fld_alpha(a3)));
    end
    w = r;
    st = ST_FAIL;
    if (s1 == 6'd0 && s3 == 6'd0) st = ST_OK;
    else if (s1 != 6'd0) begin
      cube = fld_mul(fld_mul(s1, s1), s1);
      x = 6'd1;
      if (s3 == cube) begin
        for (int i = 0; i < 63; i++) begin
          if (x == s1 && st == ST_FAIL) begin
            w = r ^ (63'd1 << i);
            st = ST_ONE;
          end
          x = fld_alpha(x);
        end
      end else begin
        inv = 6'd1;
        for (int i = 0; i < 62; i++) inv = fld_mul(inv, s1);
        sig2 = fld_mul(s3 ^ cube, inv);
        for (int i = 0; i < 63; i++) begin
          if ((fld_mul(x, x) ^ fld_mul(s1, x) ^ sig2) == 6'd0) begin
            roots++;
            flips[i] = 1'b1;
          end
          x = fld_alpha(x);
        end
        if (roots == 2) begin
          w = r ^ flips;
          st = ST_TWO;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [62:0] got,
                                 input logic [62:0] want);
    err_cnt++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // result monitor
  initial begin
    logic [62:0] ew;
    logic [1:0]  es;
    forever begin
      @(posedge clk);
      if (!rst && done) begin
        if (exp_word_q.size() == 0) report_mismatch("unexpected beat", word_out, 63'd0);
        else begin
          ew = exp_word_q.pop_front();
          es = exp_status_q.pop_front();
          if (word_out !== ew) report_mismatch("word_out", word_out, ew);
          if (status !== es) report_mismatch("status", {61'd0, status}, {61'd0, es});
        end
      end
    end
  end

  function automatic logic [62:0] rand_word();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[62:0];
  endfunction

  task automatic send_beat(input logic f, input logic [62:0] w, input bit gap);
    logic [62:0] ew;
    logic [1:0]  es;
    int n;
    if (f == FN_ENC) begin
      ew = codeword_of(w);
      es = ST_OK;
    end else correct_word(w, ew, es);
    start <= 1'b1;
    func <= f;
    word_in <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    exp_word_q.insert(exp_word_q.size(), ew);
    exp_status_q.insert(exp_status_q.size(), es);
    if (gap) begin
      n = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 5) : $urandom_range(2, 0);
      if (n > 0) begin
        start <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  endtask

  function automatic logic [62:0] flip_bits(input logic [62:0] w, input int n);
    for (int k = 0; k < n; k++) w[$urandom_range(62, 0)] ^= 1'b1;
    return w;
  endfunction

  task automatic test_directed();
    logic [62:0] cw;
    send_beat(FN_ENC, 63'd0, 0);
    send_beat(FN_ENC, {63{1'b1}}, 0);            // high bits must be ignored
    send_beat(FN_ENC, 63'h0005_5555_5555_5555, 1);
    send_beat(FN_DEC, 63'd0, 0);
    send_beat(FN_DEC, {63{1'b1}}, 0);
    cw = codeword_of({63{1'b1}});
    send_beat(FN_DEC, cw, 0);
    send_beat(FN_DEC, cw ^ 63'd1, 0);
    send_beat(FN_DEC, cw ^ (63'd1 << 62), 1);
    send_beat(FN_DEC, cw ^ 63'd1 ^ (63'd1 << 62), 0);
    send_beat(FN_DEC, cw ^ 63'h7, 0);            // three errors
    // S1 zero, S3 nonzero: m1(x) multiple x^6+x^4+x^3+x+1
    send_beat(FN_DEC, 63'h5B, 0);
    send_beat(FN_DEC, 63'h5B << 50, 1);
    for (int i = 0; i < 8; i++) send_beat(FN_DEC, flip_bits(cw, 4), 0);
  endtask

  task automatic test_random();
    logic [62:0] w;
    int sel;
    for (int i = 0; i < 1400; i++) begin
      sel = $urandom_range(9, 0);
      w = rand_word();
      if (sel < 3) send_beat(FN_ENC, w, 1);
      else if (sel < 8) send_beat(FN_DEC, flip_bits(codeword_of(w), sel - 3), 1);
      else send_beat(FN_DEC, w, 1);
    end
  endtask

  initial begin
    int wait_cnt;
    err_cnt = 0;
    rst <= 1'b1;
    start <= 1'b0;
    func <= FN_ENC;
    word_in <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    start <= 1'b0;
    wait_cnt = 0;
    while (exp_word_q.size() != 0 && wait_cnt < 1000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && exp_word_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// ----- bch_63_51_codec_unit.f -----
+incdir+rtl
rtl/bch_pkg.sv
rtl/bch_syn.sv
rtl/bch_key.sv
rtl/bch_chien.sv
rtl/bch_63_51_codec_unit.sv
verif/tb_top.sv
